>>> sv/sha256_hash_engine_core_defines.svh
// Assertion macros for the checker file.
`ifndef SHA256_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA256_HASH_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define SHA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("SHA-256 engine check failed");

// Next-cycle implication, checked at each rising edge outside reset.
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("SHA-256 engine check failed");

`endif

>>> sv/sha256_pkg.sv
`timescale 1ns / 1ps

package sha256_pkg;

   localparam logic [31:0] PadMarker = 32'h8000_0000;
   localparam logic [3:0]  LenHiSlot = 4'd14;
   localparam logic [3:0]  BlockLast = 4'd15;
   localparam logic [5:0]  RoundLast = 6'd63;
   localparam logic [2:0]  LastIdx   = 3'd7;
   localparam logic [2:0]  FullWord  = 3'd4;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
      ror32 = (v >> s) | (v << (32 - s));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      case (idx)
         3'd0:    init_hash = 32'h6a09e667;
         3'd1:    init_hash = 32'hbb67ae85;
         3'd2:    init_hash = 32'h3c6ef372;
         3'd3:    init_hash = 32'ha54ff53a;
         3'd4:    init_hash = 32'h510e527f;
         3'd5:    init_hash = 32'h9b05688c;
         3'd6:    init_hash = 32'h1f83d9ab;
         default: init_hash = 32'h5be0cd19;
      endcase
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      case (t)
         6'd0:  round_k = 32'h428a2f98;
         6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;
         6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;
         6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;
         6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;
         6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;
         6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;
         6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;
         6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;
         6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;
         6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;
         6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;
         6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;
         6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;
         6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;
         6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;
         6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;
         6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;
         6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;
         6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;
         6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;
         6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;
         6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;
         6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;
         6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;
         6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;
         6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;
         6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;
         6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;
         6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;
         6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;
         6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;
         default: round_k = 32'hc67178f2;
      endcase
   endfunction

   // Keeps the valid leading bytes of a partial last word and appends the pad byte.
   function automatic logic [31:0] pad_partial(input logic [31:0] d, input logic [2:0] nv);
      case (nv)
         3'd0:    pad_partial = PadMarker;
         3'd1:    pad_partial = {d[31:24], 24'h80_0000};
         3'd2:    pad_partial = {d[31:16], 16'h8000};
         3'd3:    pad_partial = {d[31:8], 8'h80};
         default: pad_partial = d;
      endcase
   endfunction

endpackage

>>> sv/sha256_hash_engine_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   data_word, valid_bytes, last
// rsp       out        rsp_valid/rsp_stall   digest_word, word_index, last_word
//
// A message word that does not fill a block is shifted into the window and the
// engine stays ready for the next word. The sixteenth word of a block starts the
// rounds and then the chain add, all through the single shared round unit.
// A last word is followed by its padding words, one or two compressions and the
// eight digest words, stretched by any rsp_stall.
// Synchronous active-high reset restores the initial hash and clears all counters.
module sha256_hash_engine_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sha256_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sha256_pkg::rsp_type rsp_data
);
   import sha256_pkg::*;

   state_type   state_ff, state_in;
   logic [3:0]  count_ff, count_in;
   logic [60:0] bytes_ff, bytes_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        pad_ff, pad_in;
   logic        marker_ff, marker_in;
   logic        hi_ff, hi_in;
   logic        done_ff, done_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] win_ff [16];
   logic [31:0] var_ff [8];
   logic [31:0] chain_ff [8];
   rsp_type     rsp_data_ff;

   logic        push;
   logic [31:0] push_word;
   logic        load_vars;
   logic        sched;
   logic        add_chain;
   logic        emit_ld;
   logic [2:0]  nv_eff;
   logic [63:0] bit_len;
   logic [31:0] new_w;
   logic [31:0] t1;
   logic [31:0] t2;

   assign bit_len = {bytes_ff, 3'b000};
   assign new_w = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9] + small_sigma1(win_ff[14]);
   assign t1 = var_ff[7] + big_sigma1(var_ff[4])
             + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
             + round_k(round_ff) + win_ff[0];
   assign t2 = big_sigma0(var_ff[0])
             + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      bytes_in     = bytes_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;
      pad_in       = pad_ff;
      marker_in    = marker_ff;
      hi_in        = hi_ff;
      done_in      = done_ff;
      push         = 1'b0;
      push_word    = '0;
      load_vars    = 1'b0;
      sched        = 1'b0;
      add_chain    = 1'b0;
      emit_ld      = 1'b0;
      nv_eff       = FullWord;
      if (req_data.last && req_data.valid_bytes < FullWord) begin
         nv_eff = req_data.valid_bytes;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               push     = 1'b1;
               bytes_in = bytes_ff + {58'd0, nv_eff};
               if (req_data.last) begin
                  push_word = pad_partial(req_data.data_word, nv_eff);
                  pad_in    = 1'b1;
                  marker_in = (nv_eff == FullWord);
                  state_in  = ST_PAD;
               end else begin
                  push_word = req_data.data_word;
               end
            end
         end
         ST_PAD: begin
            push = 1'b1;
            if (marker_ff) begin
               push_word = PadMarker;
               marker_in = 1'b0;
            end else if (count_ff == LenHiSlot && !hi_ff) begin
               push_word = bit_len[63:32];
               hi_in     = 1'b1;
            end else if (count_ff == BlockLast && hi_ff) begin
               push_word = bit_len[31:0];
               hi_in     = 1'b0;
               done_in   = 1'b1;
            end
         end
         ST_ROUND: begin
            sched    = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == RoundLast) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            add_chain = 1'b1;
            if (done_ff) begin
               state_in = ST_EMIT;
               pad_in   = 1'b0;
               done_in  = 1'b0;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               emit_ld = 1'b1;
               idx_in  = idx_ff + 3'd1;
               if (idx_ff == LastIdx) begin
                  state_in = ST_IDLE;
                  bytes_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (push) begin
         count_in = count_ff + 4'd1;
         if (count_ff == BlockLast) begin
            load_vars = 1'b1;
            round_in  = '0;
            state_in  = ST_ROUND;
         end
      end
      rsp_valid_in = emit_ld || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         bytes_ff     <= '0;
         round_ff     <= '0;
         idx_ff       <= '0;
         pad_ff       <= 1'b0;
         marker_ff    <= 1'b0;
         hi_ff        <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         round_ff     <= round_in;
         idx_ff       <= idx_in;
         pad_ff       <= pad_in;
         marker_ff    <= marker_in;
         hi_ff        <= hi_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The chain value shifts out during the digest and refills with the initial hash.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= init_hash(3'(i));
         end
      end else if (add_chain) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] + var_ff[i];
         end
      end else if (emit_ld) begin
         for (int i = 0; i < 7; i++) begin
            chain_ff[i] <= chain_ff[i + 1];
         end
         chain_ff[7] <= init_hash(idx_ff);
      end
   end

   // The block window doubles as the message schedule: word zero feeds each round.
   always_ff @(posedge clock) begin
      if (push || sched) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[15] <= push ? push_word : new_w;
      end
      if (load_vars) begin
         for (int i = 0; i < 8; i++) begin
            var_ff[i] <= chain_ff[i];
         end
      end else if (sched) begin
         var_ff[0] <= t1 + t2;
         var_ff[1] <= var_ff[0];
         var_ff[2] <= var_ff[1];
         var_ff[3] <= var_ff[2];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[5] <= var_ff[4];
         var_ff[6] <= var_ff[5];
         var_ff[7] <= var_ff[6];
      end
      if (emit_ld) begin
         rsp_data_ff.digest_word <= chain_ff[0];
         rsp_data_ff.word_index  <= idx_ff;
         rsp_data_ff.last_word   <= (idx_ff == LastIdx);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/sha256_checker.sv
`timescale 1ns / 1ps
`include "sha256_hash_engine_core_defines.svh"

module sha256_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input sha256_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input sha256_pkg::rsp_type rsp_data
);
   import sha256_pkg::*;

   `SHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `SHA_ASSERT_NOW(a_busy_in_digest, clock, reset, rsp_valid && rsp_data.word_index != LastIdx, req_stall)
   `SHA_ASSERT_NEXT(a_digest_order, clock, reset, rsp_valid && !rsp_stall && rsp_data.word_index != LastIdx, rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1)
   `SHA_ASSERT_NOW(a_last_flag, clock, reset, rsp_valid, rsp_data.last_word == (rsp_data.word_index == LastIdx))

endmodule

bind sha256_hash_engine_core sha256_checker u_sha256_checker (.*);
